FILE: rtl/tpbt_pkg.sv
// Shared widths and item types for the barycentric point-in-triangle test.
package tpbt_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    localparam int IN_W     = 12;
    localparam int WEIGHT_W = 24;
    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int EDGE_W   = PROD_W + 1;
    localparam int MAG_W    = EDGE_W - 1;
    localparam int DIV_W    = MAG_W + FRAC_BITS;
    localparam int OVF_W    = MAG_W + WEIGHT_W - FRAC_BITS;

    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 80;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // Setup stage plus one divider stage per quotient bit.
    localparam int NST = WEIGHT_W + 1;

    typedef logic [COORD_BITS-1:0]     coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [WEIGHT_W-1:0]       quo_t;

    localparam quo_t WMAX_Q = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam quo_t WMIN_Q = {1'b1, {(WEIGHT_W-1){1'b0}}};

    // Edge values and doubled area handed from the front to the back.
    typedef struct packed {
        edge_t e_bc;
        edge_t e_ca;
        edge_t e_ab;
        edge_t area;
    } edges_t;

    // Per-item flags that travel alongside the divider lanes.
    typedef struct packed {
        logic       in_tri;
        logic       degen;
        logic [2:0] neg;
        logic [2:0] ovf;
    } meta_t;

endpackage

FILE: rtl/tpbt_front.sv
// Front end: coordinate differences, products and edge values in three stages.
module tpbt_front
    import tpbt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [S_DATA_W-1:0] in_data,
    output logic                push,
    input  logic                q_full,
    output edges_t              edges
);

    coord_t px, py, ax, ay, bx, by, cx, cy;

    logic v1_reg, v2_reg, v3_reg;
    logic adv;

    diff_t pax_reg, pay_reg, bax_reg, bay_reg, pbx_reg, pby_reg;
    diff_t cbx_reg, cby_reg, pcx_reg, pcy_reg, acx_reg, acy_reg;

    prod_t m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg, m7_reg;
    edges_t edges_reg;

    assign px = coord_t'(in_data[0*IN_W +: IN_W]);
    assign py = coord_t'(in_data[1*IN_W +: IN_W]);
    assign ax = coord_t'(in_data[2*IN_W +: IN_W]);
    assign ay = coord_t'(in_data[3*IN_W +: IN_W]);
    assign bx = coord_t'(in_data[4*IN_W +: IN_W]);
    assign by = coord_t'(in_data[5*IN_W +: IN_W]);
    assign cx = coord_t'(in_data[6*IN_W +: IN_W]);
    assign cy = coord_t'(in_data[7*IN_W +: IN_W]);

    assign adv      = !v3_reg || !q_full;
    assign in_ready = adv;
    assign push     = v3_reg && !q_full;
    assign edges    = edges_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pax_reg <= diff_t'({1'b0, px}) - diff_t'({1'b0, ax});
            pay_reg <= diff_t'({1'b0, py}) - diff_t'({1'b0, ay});
            bax_reg <= diff_t'({1'b0, bx}) - diff_t'({1'b0, ax});
            bay_reg <= diff_t'({1'b0, by}) - diff_t'({1'b0, ay});
            pbx_reg <= diff_t'({1'b0, px}) - diff_t'({1'b0, bx});
            pby_reg <= diff_t'({1'b0, py}) - diff_t'({1'b0, by});
            cbx_reg <= diff_t'({1'b0, cx}) - diff_t'({1'b0, bx});
            cby_reg <= diff_t'({1'b0, cy}) - diff_t'({1'b0, by});
            pcx_reg <= diff_t'({1'b0, px}) - diff_t'({1'b0, cx});
            pcy_reg <= diff_t'({1'b0, py}) - diff_t'({1'b0, cy});
            acx_reg <= diff_t'({1'b0, ax}) - diff_t'({1'b0, cx});
            acy_reg <= diff_t'({1'b0, ay}) - diff_t'({1'b0, cy});

            m0_reg <= pax_reg * bay_reg;
            m1_reg <= bax_reg * pay_reg;
            m2_reg <= pbx_reg * cby_reg;
            m3_reg <= cbx_reg * pby_reg;
            m4_reg <= pcx_reg * acy_reg;
            m5_reg <= acx_reg * pcy_reg;
            m6_reg <= bax_reg * acy_reg;
            m7_reg <= acx_reg * bay_reg;

            edges_reg.e_ab <= edge_t'(m0_reg) - edge_t'(m1_reg);
            edges_reg.e_bc <= edge_t'(m2_reg) - edge_t'(m3_reg);
            edges_reg.e_ca <= edge_t'(m4_reg) - edge_t'(m5_reg);
            edges_reg.area <= edge_t'(m6_reg) - edge_t'(m7_reg);
        end
    end

endmodule

FILE: rtl/tpbt_queue.sv
// Short queue of edge values between the front end and the divider back end.
module tpbt_queue
    import tpbt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  edges_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output edges_t pop_data
);

    edges_t mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/tpbt_back.sv
// Back end: sign and overflow setup, three pipelined dividers, saturation and output.
module tpbt_back
    import tpbt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  edges_t              q_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [M_DATA_W-1:0] out_data
);

    logic adv;
    logic  valid_reg [NST];
    meta_t meta_reg  [NST];
    mag_t  den_reg   [NST];
    mag_t  rem_reg   [NST][3];
    quo_t  dlow_reg  [NST][3];
    quo_t  quo_reg   [NST][3];

    edge_t num [3];
    mag_t  num_mag [3];
    mag_t  den_mag;
    logic [DIV_W-1:0] dvd [3];

    logic out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [WEIGHT_W-1:0] w [3];

    function automatic logic inside_of(input edges_t e);
        logic le0, ge0;
        le0 = (e.e_ab[EDGE_W-1] || e.e_ab == '0) && (e.e_bc[EDGE_W-1] || e.e_bc == '0) &&
              (e.e_ca[EDGE_W-1] || e.e_ca == '0);
        ge0 = !e.e_ab[EDGE_W-1] && !e.e_bc[EDGE_W-1] && !e.e_ca[EDGE_W-1];
        return le0 || ge0;
    endfunction

    assign adv       = !out_valid_reg || out_ready;
    assign pop       = adv && q_not_empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign num[0] = q_data.e_bc;
    assign num[1] = q_data.e_ca;
    assign num[2] = q_data.e_ab;
    assign den_mag = q_data.area[EDGE_W-1] ? mag_t'(-q_data.area) : mag_t'(q_data.area);

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            num_mag[l] = num[l][EDGE_W-1] ? mag_t'(-num[l]) : mag_t'(num[l]);
            dvd[l]     = {num_mag[l], {FRAC_BITS{1'b0}}};
        end
    end

    // Setup stage: magnitudes, signs and the saturation test for each lane.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (adv)
            valid_reg[0] <= q_not_empty;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[0].in_tri <= inside_of(q_data);
            meta_reg[0].degen  <= (q_data.area == '0);
            den_reg[0] <= den_mag;
            for (int l = 0; l < 3; l++)
            begin
                meta_reg[0].neg[l] <= num[l][EDGE_W-1] ^ q_data.area[EDGE_W-1];
                // A quotient of 2^WEIGHT_W or more saturates whatever its sign.
                meta_reg[0].ovf[l] <= (OVF_W'(num_mag[l]) >=
                                       (OVF_W'(den_mag) << (WEIGHT_W - FRAC_BITS)));
                rem_reg[0][l]  <= mag_t'(dvd[l][DIV_W-1:WEIGHT_W]);
                dlow_reg[0][l] <= dvd[l][WEIGHT_W-1:0];
                quo_reg[0][l]  <= '0;
            end
        end
    end

    // One restoring quotient bit per stage, most significant bit first.
    for (genvar s = 1; s < NST; s++)
    begin : g_div
        logic [MAG_W:0] trial [3];
        logic           fits  [3];

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial[l] = {rem_reg[s-1][l], dlow_reg[s-1][l][WEIGHT_W-1]};
                fits[l]  = (trial[l] >= {1'b0, den_reg[s-1]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (adv)
                valid_reg[s] <= valid_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                meta_reg[s] <= meta_reg[s-1];
                den_reg[s]  <= den_reg[s-1];
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[s][l]  <= fits[l] ? mag_t'(trial[l] - {1'b0, den_reg[s-1]})
                                              : mag_t'(trial[l]);
                    dlow_reg[s][l] <= {dlow_reg[s-1][l][WEIGHT_W-2:0], 1'b0};
                    quo_reg[s][l]  <= {quo_reg[s-1][l][WEIGHT_W-2:0], fits[l]};
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (meta_reg[NST-1].degen)
                w[l] = '0;
            else if (meta_reg[NST-1].neg[l])
                w[l] = (meta_reg[NST-1].ovf[l] || quo_reg[NST-1][l] > WMIN_Q)
                       ? WMIN_Q : (~quo_reg[NST-1][l] + 1'b1);
            else
                w[l] = (meta_reg[NST-1].ovf[l] || quo_reg[NST-1][l] > WMAX_Q)
                       ? WMAX_Q : quo_reg[NST-1][l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= valid_reg[NST-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= M_DATA_W'({w[2], w[1], w[0],
                                       meta_reg[NST-1].degen, meta_reg[NST-1].in_tri});
    end

endmodule

FILE: rtl/triangle_point_barycentric_test.sv
// Top level of the barycentric point-in-triangle test.
// One item enters per clock cycle while the queue is not full and the output side
// does not stall. The front end forms the edge values (differences, products,
// cross terms) in registered steps, the queue holds them, a setup stage sets up signs
// and saturation, 24 divider stages each produce one quotient bit of the three
// weights, and one output register applies sign and saturation. A four-entry queue
// between the edge front end and the divider back end lets either side stall on its
// own. With a zero doubled area the degenerate flag is set and all weights read zero.
module triangle_point_barycentric_test
    import tpbt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // pixel_x, pixel_y, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
    // vertex_c_x, vertex_c_y (12 bits each, from bit 0 up)
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // inside_res, degenerate, weight_a, weight_b, weight_c (24 bits each),
    // zero fill to 80 bits
    output logic [M_DATA_W-1:0] m_tdata
);

    logic   push, q_full, pop, q_not_empty;
    edges_t push_data, pop_data;

    tpbt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .push     (push),
        .q_full   (q_full),
        .edges    (push_data)
    );

    tpbt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    tpbt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (pop_data),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata)
    );

endmodule
